### src/ssur_pkg.sv
// Shared constants, types and ring helpers for the sensor sample unpack ring.
`default_nettype none

package ssur_pkg;

  localparam int unsigned RING_DEPTH  = 32;
  localparam int unsigned SAMPLE_BITS = 18;
  localparam int unsigned IDX_W       = $clog2(RING_DEPTH);
  localparam int unsigned OUT_W       = 18;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned PART_W      = 16;
  localparam int unsigned CFG_W       = 2;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PHASE_W-1:0]     phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic upd;   // take the input item and update the ring state
    logic load;  // read the ring and load the result register
  } cmd_t;

  function automatic idx_t ring_next(input idx_t i);
    idx_t r;
    if (i == IDX_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  function automatic idx_t ring_count(input idx_t h, input idx_t t);
    logic [IDX_W:0] d;
    d = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      d = d + (IDX_W + 1)'(RING_DEPTH);
    end
    return d[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/sensor_sample_unpack_ring_top.sv
// Top level of the sensor sample unpack ring: controller and datapath.
//
// The input channel carries one item per transfer: either a raw byte from
// the sensor's sample FIFO (op 0) or a request to pop the oldest unread
// sample (op 1). Three bytes, most significant first, form one value that
// is cut to the sample width; with two channels active a red value is
// followed by an IR value and the pair is stored as one ring entry.
// Every item gives exactly one result transfer on the output channel, with
// the oldest unread and latest samples, the unread count and the flags.
// For a byte the accepting edge takes it into the assembly and, for a
// completed sample, advances the head and writes the sample memory. In the
// read state, once the result register is free, an edge reads the memory
// at the oldest entry and at the head into the result register, and a pop
// advances the tail there. No new item is taken until that read is done.
// The result register holds its transfer while the receiver stalls; a new
// item may be taken meanwhile, and its read step waits until the register
// is free. Reset empties the ring, clears byte assembly and sets two
// active channels; the memories themselves are not cleared. The channel
// register may be written only while no item is in flight.
`default_nettype none

module sensor_sample_unpack_ring_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssur_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [7:0]                    data_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               sample_stored_o,
  output logic                               popped_o,
  output logic [ssur_pkg::OUT_W-1:0]         oldest_red_o,
  output logic [ssur_pkg::OUT_W-1:0]         oldest_ir_o,
  output logic [ssur_pkg::OUT_W-1:0]         latest_red_o,
  output logic [ssur_pkg::OUT_W-1:0]         latest_ir_o,
  output logic [ssur_pkg::COUNT_W-1:0]       unread_count_o,
  output logic                               overrun_o
);
  import ssur_pkg::*;

  cmd_t cmd;

  // The controller sequences the update and read steps of each item.
  ssur_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath owns the ring, the byte assembly and the result register.
  ssur_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_stored_o (sample_stored_o),
    .popped_o        (popped_o),
    .oldest_red_o    (oldest_red_o),
    .oldest_ir_o     (oldest_ir_o),
    .latest_red_o    (latest_red_o),
    .latest_ir_o     (latest_ir_o),
    .unread_count_o  (unread_count_o),
    .overrun_o       (overrun_o)
  );

endmodule

`default_nettype wire

### src/ssur_ctrl.sv
// Controller state machine: input handshake, ring read sequencing and output valid.
`default_nettype none

module ssur_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ssur_pkg::cmd_t     cmd_o
);
  import ssur_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register may be reloaded when empty or emptied in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.upd = 1'b1;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/ssur_dp.sv
// Datapath: byte assembly, head and tail pointers, sample memories and result register.
`default_nettype none

module ssur_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ssur_pkg::cmd_t                cmd_i,
  input  wire logic                          op_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssur_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                               sample_stored_o,
  output logic                               popped_o,
  output logic [ssur_pkg::OUT_W-1:0]         oldest_red_o,
  output logic [ssur_pkg::OUT_W-1:0]         oldest_ir_o,
  output logic [ssur_pkg::OUT_W-1:0]         latest_red_o,
  output logic [ssur_pkg::OUT_W-1:0]         latest_ir_o,
  output logic [ssur_pkg::COUNT_W-1:0]       unread_count_o,
  output logic                               overrun_o
);
  import ssur_pkg::*;

  // Ring state.
  idx_t                head_q, head_d;
  idx_t                tail_q, tail_d;
  phase_t              phase_q, phase_d;
  logic [PART_W-1:0]   partial_q, partial_d;
  sample_t             pending_q, pending_d;
  logic [CFG_W-1:0]    chan_q;
  logic                op_q, op_d;
  logic                stored_q, stored_d;
  logic                ovr_q, ovr_d;

  // Sample memories, no reset.
  sample_t             red_mem [RING_DEPTH];
  sample_t             ir_mem  [RING_DEPTH];

  // Result register.
  sample_t             old_red_q, old_ir_q, new_red_q, new_ir_q;
  logic                old_vld_q, res_stored_q, res_popped_q, res_ovr_q;
  logic [COUNT_W-1:0]  res_count_q;

  phase_t              ph, pos;
  logic                two;
  logic [PART_W+7:0]   assembled;
  sample_t             value;
  idx_t                head_nxt, tail_nxt, wr_addr, old_addr;
  logic                we_red, we_ir;
  sample_t             wr_red;
  logic                nonempty, pop_now;

  assign two       = chan_q[1];
  assign ph        = (phase_q > 3'd5) ? '0 : phase_q;
  assign pos       = (ph >= 3'd3) ? ph - 3'd3 : ph;
  assign assembled = {partial_q, data_byte_i};
  assign value     = assembled[SAMPLE_BITS-1:0];
  assign head_nxt  = ring_next(head_q);
  assign tail_nxt  = ring_next(tail_q);
  assign wr_addr   = head_nxt;
  assign wr_red    = two ? pending_q : value;
  assign nonempty  = (ring_count(head_q, tail_q) != '0);
  assign pop_now   = cmd_i.load && (op_q == OP_POP) && nonempty;
  assign old_addr  = tail_nxt;

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    pending_d = pending_q;
    head_d    = head_q;
    tail_d    = tail_q;
    op_d      = op_q;
    stored_d  = stored_q;
    ovr_d     = ovr_q;
    we_red    = 1'b0;
    we_ir     = 1'b0;
    if (cmd_i.upd) begin
      op_d     = op_i;
      stored_d = 1'b0;
      ovr_d    = 1'b0;
      if (op_i == OP_BYTE) begin
        case (pos)
          3'd0: begin
            partial_d = PART_W'(data_byte_i);
            phase_d   = ph + 3'd1;
          end
          3'd1: begin
            partial_d = {partial_q[7:0], data_byte_i};
            phase_d   = ph + 3'd1;
          end
          default: begin
            if (two && (ph == 3'd2)) begin
              pending_d = value;
              phase_d   = 3'd3;
            end else begin
              // Completed sample: advance head and write it there.
              we_red   = 1'b1;
              we_ir    = two;
              head_d   = head_nxt;
              stored_d = 1'b1;
              phase_d  = '0;
              if (head_nxt == tail_q) begin
                tail_d = tail_nxt;
                ovr_d  = 1'b1;
              end
            end
          end
        endcase
      end
    end else if (pop_now) begin
      tail_d = tail_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      phase_q   <= '0;
      partial_q <= '0;
      pending_q <= '0;
      chan_q    <= CFG_W'(2);
      op_q      <= OP_BYTE;
      stored_q  <= 1'b0;
      ovr_q     <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      phase_q   <= phase_d;
      partial_q <= partial_d;
      pending_q <= pending_d;
      op_q      <= op_d;
      stored_q  <= stored_d;
      ovr_q     <= ovr_d;
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_red) begin
      red_mem[wr_addr] <= wr_red;
    end
    if (we_ir) begin
      ir_mem[wr_addr] <= value;
    end
  end

  // Reads at the oldest unread entry and at the head, registered as the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      old_red_q    <= red_mem[old_addr];
      old_ir_q     <= ir_mem[old_addr];
      new_red_q    <= red_mem[head_q];
      new_ir_q     <= ir_mem[head_q];
      old_vld_q    <= nonempty;
      res_stored_q <= (op_q == OP_BYTE) && stored_q;
      res_ovr_q    <= (op_q == OP_BYTE) && ovr_q;
      res_popped_q <= pop_now;
      res_count_q  <= COUNT_W'(ring_count(head_q, tail_d));
    end
  end

  assign sample_stored_o = res_stored_q;
  assign popped_o        = res_popped_q;
  assign oldest_red_o    = old_vld_q ? OUT_W'(old_red_q) : '0;
  assign oldest_ir_o     = old_vld_q ? OUT_W'(old_ir_q) : '0;
  assign latest_red_o    = OUT_W'(new_red_q);
  assign latest_ir_o     = OUT_W'(new_ir_q);
  assign unread_count_o  = res_count_q;
  assign overrun_o       = res_ovr_q;

endmodule

`default_nettype wire

### src/ssur_chk.sv
// Port-level checker for the sensor sample unpack ring, bound to the top level.
`default_nettype none

module ssur_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          sample_stored_o,
  input wire logic                          popped_o,
  input wire logic                          overrun_chk_i,
  input wire logic [ssur_pkg::COUNT_W-1:0]  unread_count_o
);
  import ssur_pkg::*;

  // A stalled result transfer stays offered with the same count.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(unread_count_o))
    else $error("stalled result was withdrawn or changed");

  // An accepted item keeps the input side busy for its read step.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without a read step");

  // A pop never also stores or overruns.
  a_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && popped_o |-> !sample_stored_o && !overrun_chk_i)
    else $error("pop result also reports a store");

  // An overrun only comes with a store and leaves the ring full.
  a_overrun_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overrun_chk_i |->
      sample_stored_o && (unread_count_o == COUNT_W'(RING_DEPTH - 1)))
    else $error("overrun without a store into a full ring");

endmodule

bind sensor_sample_unpack_ring_top ssur_chk u_ssur_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sample_stored_o (sample_stored_o),
  .popped_o        (popped_o),
  .overrun_chk_i   (overrun_o),
  .unread_count_o  (unread_count_o)
);

`default_nettype wire
